// File: src/sfa_pkg.sv
// shared types, codes and constants for the swap frame allocator
// no dependencies
`timescale 1ns / 1ps
package sfa_pkg;

   localparam int DefFrames  = 64;
   localparam int DefPidBits = 16;
   localparam int PAGE_W     = 6;
   localparam int NUM_W      = 7;

   // operation selector
   localparam logic [2:0] KIND_FIND    = 3'd0;
   localparam logic [2:0] KIND_ALLOC   = 3'd1;
   localparam logic [2:0] KIND_FREE    = 3'd2;
   localparam logic [2:0] KIND_LOOKUP  = 3'd3;
   localparam logic [2:0] KIND_COMPACT = 3'd4;

   // result status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FRAG     = 3'd1;
   localparam logic [2:0] ST_NOSPACE  = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;

   // cell row operation
   localparam logic [1:0] MODE_HOLD  = 2'd0;
   localparam logic [1:0] MODE_SHIFT = 2'd1;
   localparam logic [1:0] MODE_SORT  = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic             parity;
      logic [NUM_W-1:0] n;
   } cell_ctl_type;

endpackage

// File: src/swap_frame_allocator_core.sv
// swap frame allocator: row of frame cells rotated past a head controller
// depends on sfa_pkg and sfa_cell
`timescale 1ns / 1ps
//
// channel  | direction | handshake              | payload
// req_     | in        | req_valid / req_ready  | kind, pid, page_number, frame, count
// rsp_     | out       | rsp_valid / rsp_ready  | status, frame_result, moved, move_from,
//          |           |                        | move_to, last
// csr_     | in        | csr_we (no wait)       | frames_in_use
//
// every transaction rotates the whole cell row once past the head, then registers
// the final result and returns to idle before it takes the next one; compaction
// then runs odd-even exchange rounds in the row
// the rotation pauses while a result waits in the output register
// reset frees all frames and loads frames_in_use with 64; owner fields hold garbage
// until written and are only read for occupied frames
module swap_frame_allocator_core #(
   parameter int FRAMES   = sfa_pkg::DefFrames,
   parameter int PID_BITS = sfa_pkg::DefPidBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_pid,
   input  logic [5:0]  req_page_number,
   input  logic [5:0]  req_frame,
   input  logic [6:0]  req_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_frame_result,
   output logic        rsp_moved,
   output logic [5:0]  rsp_move_from,
   output logic [5:0]  rsp_move_to,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [6:0]  csr_frames_in_use
);
   import sfa_pkg::*;

   localparam int FW    = $clog2(FRAMES);
   localparam int PW    = (PID_BITS < 16) ? PID_BITS : 16;
   localparam logic [FW-1:0]    LAST_STEP = FW'(FRAMES - 1);
   localparam logic [NUM_W-1:0] FRAMES_N  = NUM_W'(FRAMES);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_SORT  = 2'd3;

   // cell row
   logic              c_occ  [FRAMES];
   logic [PW-1:0]     c_pid  [FRAMES];
   logic [PAGE_W-1:0] c_page [FRAMES];
   cell_ctl_type      ctl;

   // head write-back into the tail cell
   logic              wb_occ;
   logic [PW-1:0]     wb_pid;
   logic [PAGE_W-1:0] wb_page;

   genvar g;
   generate
      for (g = 0; g < FRAMES; g++) begin : g_cell
         if (g == FRAMES - 1) begin : g_tail
            sfa_cell #(.IDX(g), .PID_W(PW)) u_cell (
               .clock(clock), .reset(reset), .ctl(ctl),
               .up_occ(wb_occ), .up_pid(wb_pid), .up_page(wb_page),
               .dn_occ(c_occ[g-1]), .dn_pid(c_pid[g-1]), .dn_page(c_page[g-1]),
               .occ(c_occ[g]), .pid(c_pid[g]), .page(c_page[g]));
         end else if (g == 0) begin : g_head
            sfa_cell #(.IDX(g), .PID_W(PW)) u_cell (
               .clock(clock), .reset(reset), .ctl(ctl),
               .up_occ(c_occ[g+1]), .up_pid(c_pid[g+1]), .up_page(c_page[g+1]),
               .dn_occ(c_occ[g]), .dn_pid(c_pid[g]), .dn_page(c_page[g]),
               .occ(c_occ[g]), .pid(c_pid[g]), .page(c_page[g]));
         end else begin : g_mid
            sfa_cell #(.IDX(g), .PID_W(PW)) u_cell (
               .clock(clock), .reset(reset), .ctl(ctl),
               .up_occ(c_occ[g+1]), .up_pid(c_pid[g+1]), .up_page(c_page[g+1]),
               .dn_occ(c_occ[g-1]), .dn_pid(c_pid[g-1]), .dn_page(c_page[g-1]),
               .occ(c_occ[g]), .pid(c_pid[g]), .page(c_page[g]));
         end
      end
   endgenerate

   // control registers
   logic [1:0]        state_ff, state_in;
   logic [FW-1:0]     step_ff, step_in;
   logic [NUM_W-1:0]  csr_ff, csr_in;
   logic [NUM_W-1:0]  n_ff, n_in;
   logic [2:0]        kind_ff, kind_in;
   logic [PW-1:0]     pid_ff, pid_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [NUM_W-1:0]  start_ff, start_in;
   logic [NUM_W-1:0]  count_ff, count_in;
   logic              err_ff, err_in;
   logic [NUM_W-1:0]  run_ff, run_in;
   logic [NUM_W-1:0]  total_ff, total_in;
   logic              found_ff, found_in;
   logic [5:0]        res_ff, res_in;
   logic [NUM_W-1:0]  dst_ff, dst_in;
   logic              pend_ff, pend_in;
   logic [5:0]        pfrom_ff, pfrom_in;
   logic [5:0]        pto_ff, pto_in;

   // output register
   logic       rv_ff, rv_in;
   logic [2:0] rst_ff, rst_in;
   logic [5:0] rfr_ff, rfr_in;
   logic       rmv_ff, rmv_in;
   logic [5:0] rfrom_ff, rfrom_in;
   logic [5:0] rto_ff, rto_in;
   logic       rlast_ff, rlast_in;

   logic             out_free, go, emit, active, pid_hit;
   logic [NUM_W-1:0] i_n, run_next, total_next, end_n;
   // one extra bit so a run far past the end cannot wrap back into range
   logic [NUM_W:0]   sum_n;

   assign out_free  = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign i_n       = NUM_W'(step_ff);
   assign active    = i_n < n_ff;
   assign pid_hit   = c_pid[0] == pid_ff;
   assign end_n     = start_ff + count_ff;
   assign sum_n     = {2'b00, req_frame} + {1'b0, req_count};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      csr_in   = csr_we ? csr_frames_in_use : csr_ff;
      n_in     = n_ff;
      kind_in  = kind_ff;
      pid_in   = pid_ff;
      page_in  = page_ff;
      start_in = start_ff;
      count_in = count_ff;
      err_in   = err_ff;
      run_in   = run_ff;
      total_in = total_ff;
      found_in = found_ff;
      res_in   = res_ff;
      dst_in   = dst_ff;
      pend_in  = pend_ff;
      pfrom_in = pfrom_ff;
      pto_in   = pto_ff;

      rv_in    = rsp_ready ? 1'b0 : rv_ff;
      rst_in   = rst_ff;
      rfr_in   = rfr_ff;
      rmv_in   = rmv_ff;
      rfrom_in = rfrom_ff;
      rto_in   = rto_ff;
      rlast_in = rlast_ff;

      ctl.mode   = MODE_HOLD;
      ctl.parity = step_ff[0];
      ctl.n      = n_ff;

      wb_occ  = c_occ[0];
      wb_pid  = c_pid[0];
      wb_page = c_page[0];

      go         = 1'b0;
      emit       = 1'b0;
      run_next   = c_occ[0] ? '0 : run_ff + 1'b1;
      total_next = c_occ[0] ? total_ff : total_ff + 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // clamp the frame count and capture the transaction
               if (csr_ff == '0) begin
                  n_in = NUM_W'(1);
               end else if (csr_ff > FRAMES_N) begin
                  n_in = FRAMES_N;
               end else begin
                  n_in = csr_ff;
               end
               kind_in  = req_kind;
               pid_in   = PW'(req_pid);
               page_in  = req_page_number;
               start_in = {1'b0, req_frame};
               count_in = req_count;
               err_in   = (req_kind > KIND_COMPACT)
                          || ((req_kind == KIND_FIND || req_kind == KIND_ALLOC)
                              && req_count == '0)
                          || (req_kind == KIND_ALLOC && sum_n > {1'b0, n_in});
               run_in   = '0;
               total_in = '0;
               found_in = 1'b0;
               res_in   = '0;
               dst_in   = '0;
               pend_in  = 1'b0;
               step_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // the row rotates only while a move result can be placed
            go = out_free;
            if (go) begin
               ctl.mode = MODE_SHIFT;
               if (!err_ff) begin
                  case (kind_ff)
                     KIND_FIND: begin
                        if (active && !found_ff) begin
                           run_in   = run_next;
                           total_in = total_next;
                           if (run_next >= count_ff) begin
                              found_in = 1'b1;
                              res_in   = 6'(i_n + 1'b1 - count_ff);
                           end
                        end
                     end
                     KIND_ALLOC: begin
                        if (i_n >= start_ff && i_n < end_n) begin
                           wb_occ  = 1'b1;
                           wb_pid  = pid_ff;
                           wb_page = 6'(i_n - start_ff);
                        end
                     end
                     KIND_FREE: begin
                        if (active && c_occ[0] && pid_hit) begin
                           wb_occ = 1'b0;
                        end
                     end
                     KIND_LOOKUP: begin
                        if (active && !found_ff && c_occ[0] && pid_hit
                            && c_page[0] == page_ff) begin
                           found_in = 1'b1;
                           res_in   = 6'(i_n);
                        end
                     end
                     KIND_COMPACT: begin
                        if (active && c_occ[0]) begin
                           if (i_n != dst_ff) begin
                              // previous move goes out, this one waits for last
                              emit     = pend_ff;
                              pend_in  = 1'b1;
                              pfrom_in = 6'(i_n);
                              pto_in   = 6'(dst_ff);
                           end
                           dst_in = dst_ff + 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (emit) begin
                  rv_in    = 1'b1;
                  rst_in   = ST_OK;
                  rfr_in   = '0;
                  rmv_in   = 1'b1;
                  rfrom_in = pfrom_ff;
                  rto_in   = pto_ff;
                  rlast_in = 1'b0;
               end
               step_in = step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  step_in  = '0;
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rfr_in   = '0;
               rmv_in   = 1'b0;
               rfrom_in = '0;
               rto_in   = '0;
               rlast_in = 1'b1;
               state_in = S_IDLE;
               if (err_ff) begin
                  rst_in = ST_RANGE;
               end else begin
                  case (kind_ff)
                     KIND_FIND: begin
                        if (found_ff) begin
                           rst_in = ST_OK;
                           rfr_in = res_ff;
                        end else begin
                           rst_in = (total_ff >= count_ff) ? ST_FRAG : ST_NOSPACE;
                        end
                     end
                     KIND_LOOKUP: begin
                        rst_in = found_ff ? ST_OK : ST_NOTFOUND;
                        rfr_in = res_ff;
                     end
                     KIND_COMPACT: begin
                        rst_in   = ST_OK;
                        rmv_in   = pend_ff;
                        rfrom_in = pend_ff ? pfrom_ff : 6'd0;
                        rto_in   = pend_ff ? pto_ff : 6'd0;
                        pend_in  = 1'b0;
                        state_in = S_SORT;
                     end
                     default: begin
                        rst_in = ST_OK;
                     end
                  endcase
               end
            end
         end
         S_SORT: begin
            // odd-even exchange rounds pack occupied frames to the bottom
            ctl.mode = MODE_SORT;
            step_in  = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         csr_ff   <= NUM_W'(64);
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         csr_ff   <= csr_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
      n_ff     <= n_in;
      kind_ff  <= kind_in;
      pid_ff   <= pid_in;
      page_ff  <= page_in;
      start_ff <= start_in;
      count_ff <= count_in;
      err_ff   <= err_in;
      run_ff   <= run_in;
      total_ff <= total_in;
      found_ff <= found_in;
      res_ff   <= res_in;
      dst_ff   <= dst_in;
      pfrom_ff <= pfrom_in;
      pto_ff   <= pto_in;
      rst_ff   <= rst_in;
      rfr_ff   <= rfr_in;
      rmv_ff   <= rmv_in;
      rfrom_ff <= rfrom_in;
      rto_ff   <= rto_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = rst_ff;
   assign rsp_frame_result = rfr_ff;
   assign rsp_moved        = rmv_ff;
   assign rsp_move_from    = rfrom_ff;
   assign rsp_move_to      = rto_ff;
   assign rsp_last         = rlast_ff;

   // only compaction emits results while the row rotates
   a_scan_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && emit) |-> kind_ff == KIND_COMPACT)
      else $error("move result outside compaction");

   // no pending move survives past the final result
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("pending move left behind");

   // compaction target never runs ahead of the head frame
   a_dst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> dst_ff <= NUM_W'(step_ff))
      else $error("destination ahead of scan");

   // the row rotates only when a result can be placed
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && rv_ff && !rsp_ready) |=> $stable(step_ff))
      else $error("rotation during output stall");

endmodule

// File: src/sfa_cell.sv
// one frame cell of the allocator row: occupied bit, owner pid and page
// depends on sfa_pkg
`timescale 1ns / 1ps
module sfa_cell #(
   parameter int IDX    = 0,
   parameter int PID_W  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sfa_pkg::cell_ctl_type        ctl,
   input  logic                         up_occ,
   input  logic [PID_W-1:0]             up_pid,
   input  logic [sfa_pkg::PAGE_W-1:0]   up_page,
   input  logic                         dn_occ,
   input  logic [PID_W-1:0]             dn_pid,
   input  logic [sfa_pkg::PAGE_W-1:0]   dn_page,
   output logic                         occ,
   output logic [PID_W-1:0]             pid,
   output logic [sfa_pkg::PAGE_W-1:0]   page
);
   import sfa_pkg::*;

   localparam logic [NUM_W-1:0] SELF_N = NUM_W'(IDX);
   localparam logic [NUM_W-1:0] NEXT_N = NUM_W'(IDX + 1);
   localparam logic             MY_PAR = 1'(IDX % 2);

   logic              occ_ff, occ_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              take_up, take_dn;

   always_comb begin
      // odd-even exchange: a free left frame swaps with an occupied right one
      take_up = 1'b0;
      take_dn = 1'b0;
      if (ctl.mode == MODE_SORT) begin
         if (ctl.parity == MY_PAR) begin
            take_up = (NEXT_N < ctl.n) && !occ_ff && up_occ;
         end else begin
            take_dn = (IDX > 0) && (SELF_N < ctl.n) && !dn_occ && occ_ff;
         end
      end
      occ_in  = occ_ff;
      pid_in  = pid_ff;
      page_in = page_ff;
      if (ctl.mode == MODE_SHIFT || take_up) begin
         occ_in  = up_occ;
         pid_in  = up_pid;
         page_in = up_page;
      end else if (take_dn) begin
         occ_in  = dn_occ;
         pid_in  = dn_pid;
         page_in = dn_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      pid_ff  <= pid_in;
      page_ff <= page_in;
   end

   assign occ  = occ_ff;
   assign pid  = pid_ff;
   assign page = page_ff;

endmodule
